>>> sv/krt_pkg.sv
package krt_pkg;

	localparam int NUM_KEYS     = 102;
	localparam int QUEUE_SLOTS  = 6;
	localparam int REPORT_CODES = 6;
	localparam int KEY_W        = 7;
	localparam int CODE_W       = 8;
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 56;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic [1:0] {
		Q_HOLD,
		Q_PUSH,
		Q_REMOVE
	} queue_op_t;

	typedef struct packed {
		queue_op_t op;
		logic      commit;
		key_t      key;
		code_t     usage;
	} queue_cmd_t;

endpackage

>>> sv/key_rollover_report_tracker_core.sv
// Builds six-key-rollover reports from scanned key samples. Each sample that
// turns a key from open to closed or back yields one report transaction: the
// six most recent held non-modifier usage codes, newest in the lowest byte,
// zero for an empty slot, and the held modifier mask in the top byte. Samples
// that change nothing, or whose key index lies beyond the matrix, give no
// report. The block takes one sample every cycle while no report waits on
// the output; a sample goes through an input register and then a result
// register, from which its report is shown on the output. The held bit of a
// sample is read from the map as the sample is taken. The held map, queue and
// mask update as a sample moves from the input register to the result
// register. A report that waits on the output keeps a sample already in the
// input register there and so holds the input back until the report is taken.
module key_rollover_report_tracker_core import krt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// key_index[6:0], key_closed[7], usage_code[15:8]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// is_modifier_key[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// slot_code_0[7:0] .. slot_code_5[47:40], modifier_mask[55:48]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic  in_valid_s1;
	key_t  key_s1;
	logic  closed_s1;
	code_t usage_s1;
	logic  mod_s1;
	logic  held_s1;

	logic                  out_valid_s2;
	logic [OUT_DATA_W-1:0] out_data_s2;

	logic [NUM_KEYS-1:0] held_q;
	code_t               mods_q;

	key_t       in_key;
	logic       in_key_ok;
	logic       held_rd;
	logic       advance;
	logic       in_range;
	logic       held_bit;
	logic       press;
	logic       release_evt;
	logic       change;
	logic       commit;
	code_t      mods_d;
	queue_cmd_t qcmd;
	logic [REPORT_CODES*CODE_W-1:0] next_codes;

	assign advance  = !out_valid_s2 || m_tready;
	assign s_tready = !in_valid_s1 || advance;

	assign in_key    = s_tdata[KEY_W-1:0];
	assign in_key_ok = {1'b0, in_key} < (KEY_W+1)'(NUM_KEYS);

	always_comb begin
		held_rd = in_key_ok ? held_q[in_key] : 1'b0;
		if (commit && key_s1 == in_key) begin
			held_rd = closed_s1;
		end
	end

	assign in_range    = {1'b0, key_s1} < (KEY_W+1)'(NUM_KEYS);
	assign held_bit    = held_s1;
	assign press       = closed_s1 && !held_bit;
	assign release_evt = !closed_s1 && held_bit;
	assign change      = in_valid_s1 && in_range && (press || release_evt);
	assign commit      = change && advance;

	always_comb begin
		qcmd.op     = Q_HOLD;
		qcmd.commit = commit && !mod_s1;
		qcmd.key    = key_s1;
		qcmd.usage  = usage_s1;
		if (!mod_s1) begin
			if (press) begin
				qcmd.op = Q_PUSH;
			end else if (release_evt) begin
				qcmd.op = Q_REMOVE;
			end
		end
	end

	always_comb begin
		mods_d = mods_q;
		if (mod_s1) begin
			if (press) begin
				mods_d = mods_q | usage_s1;
			end else if (release_evt) begin
				mods_d = mods_q & ~usage_s1;
			end
		end
	end

	krt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (qcmd),
		.next_codes (next_codes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
			held_q       <= '0;
			mods_q       <= '0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_s2 <= change;
			end
			if (commit) begin
				held_q[key_s1] <= closed_s1;
				mods_q         <= mods_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1    <= s_tdata[KEY_W-1:0];
			closed_s1 <= s_tdata[KEY_W];
			usage_s1  <= s_tdata[KEY_W+1 +: CODE_W];
			mod_s1    <= s_tuser;
			held_s1   <= held_rd;
		end
		if (commit) begin
			out_data_s2 <= {mods_d, next_codes};
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_data_s2;

endmodule

>>> sv/krt_queue.sv
module krt_queue import krt_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  queue_cmd_t                     cmd,
	output logic [REPORT_CODES*CODE_W-1:0] next_codes
);

	key_t  slot_key_q   [QUEUE_SLOTS];
	code_t slot_usage_q [QUEUE_SLOTS];
	logic  [QUEUE_SLOTS-1:0] slot_valid_q;

	key_t  key_d   [QUEUE_SLOTS];
	code_t usage_d [QUEUE_SLOTS];
	logic  [QUEUE_SLOTS-1:0] valid_d;

	logic [QUEUE_SLOTS-1:0] hit;
	logic [QUEUE_SLOTS-1:0] at_or_behind;

	always_comb begin
		for (int i = 0; i < QUEUE_SLOTS; i++) begin
			hit[i] = slot_valid_q[i] && (slot_key_q[i] == cmd.key);
		end
		at_or_behind[0] = hit[0];
		for (int i = 1; i < QUEUE_SLOTS; i++) begin
			at_or_behind[i] = at_or_behind[i-1] | hit[i];
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_SLOTS; i++) begin
			key_d[i]   = slot_key_q[i];
			usage_d[i] = slot_usage_q[i];
			valid_d[i] = slot_valid_q[i];
		end
		case (cmd.op)
			Q_PUSH: begin
				for (int i = QUEUE_SLOTS - 1; i > 0; i--) begin
					key_d[i]   = slot_key_q[i-1];
					usage_d[i] = slot_usage_q[i-1];
					valid_d[i] = slot_valid_q[i-1];
				end
				key_d[0]   = cmd.key;
				usage_d[0] = cmd.usage;
				valid_d[0] = 1'b1;
			end
			Q_REMOVE: begin
				for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
					if (at_or_behind[i]) begin
						key_d[i]   = slot_key_q[i+1];
						usage_d[i] = slot_usage_q[i+1];
						valid_d[i] = slot_valid_q[i+1];
					end
				end
				if (at_or_behind[QUEUE_SLOTS-1]) begin
					valid_d[QUEUE_SLOTS-1] = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		next_codes = '0;
		for (int j = 0; j < REPORT_CODES; j++) begin
			if (j < QUEUE_SLOTS) begin
				if (valid_d[j]) begin
					next_codes[j*CODE_W +: CODE_W] = usage_d[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (cmd.commit) begin
			slot_valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < QUEUE_SLOTS; i++) begin
				slot_key_q[i]   <= key_d[i];
				slot_usage_q[i] <= usage_d[i];
			end
		end
	end

endmodule

>>> sv/krt_checker.sv
module krt_checker import krt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A report that waits holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("report changed while stalled");

	// The input side never stalls while the output side is taking transactions.
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output ready");

	// The input side stalls only behind a waiting report.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting report");

endmodule

bind key_rollover_report_tracker_core krt_checker u_krt_checker (.*);
